### rtl/core/nhfe_pkg.sv
package nhfe_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [7:0] FRM_PREAMBLE  = 8'h00;
  localparam logic [7:0] FRM_START1    = 8'h00;
  localparam logic [7:0] FRM_START2    = 8'hFF;
  localparam logic [7:0] FRM_POSTAMBLE = 8'h00;
  localparam logic [7:0] FRM_HOST_TFI  = 8'hD4;

  typedef logic [2:0] idx_t;

  localparam idx_t IDX_PRE   = 3'd0;
  localparam idx_t IDX_SC1   = 3'd1;
  localparam idx_t IDX_SC2   = 3'd2;
  localparam idx_t IDX_LEN   = 3'd3;
  localparam idx_t IDX_LCS   = 3'd4;
  localparam idx_t IDX_TFI   = 3'd5;
  localparam idx_t IDX_DCS   = 3'd0;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] payload_len;
    logic [7:0] payload_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_run;
    logic       frame_done;
  } beat_t;

endpackage

### rtl/core/nhfe_in_reg.sv
module nhfe_in_reg
  import nhfe_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  consume,
  output logic  item_vld,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || consume;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (consume ? 1'b0 : valid_r);
  assign item_vld  = valid_r;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### rtl/core/nhfe_seq.sv
module nhfe_seq
  import nhfe_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  item_vld,
  input  item_t item,
  input  logic  out_ok,
  output logic  beat_vld,
  output beat_t beat,
  output logic  consume,
  output logic [7:0] sum_q
);

  idx_t       idx_r, idx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] len, lcs, dcs;
  logic       fire;

  assign len = item.payload_len + 8'd1;
  assign lcs = 8'd0 - len;
  assign dcs = 8'd0 - sum_r;

  always_comb begin
    beat = '0;
    unique case (item.op)
      OP_START: begin
        unique case (idx_r)
          IDX_PRE: beat.frame_byte = FRM_PREAMBLE;
          IDX_SC1: beat.frame_byte = FRM_START1;
          IDX_SC2: beat.frame_byte = FRM_START2;
          IDX_LEN: beat.frame_byte = len;
          IDX_LCS: beat.frame_byte = lcs;
          default: beat.frame_byte = FRM_HOST_TFI;
        endcase
        beat.last_of_run = (idx_r == IDX_TFI);
      end
      OP_DATA: begin
        beat.frame_byte  = item.payload_byte;
        beat.last_of_run = 1'b1;
      end
      OP_FINISH: begin
        if (idx_r == IDX_DCS) begin
          beat.frame_byte = dcs;
        end else begin
          beat.frame_byte  = FRM_POSTAMBLE;
          beat.last_of_run = 1'b1;
          beat.frame_done  = 1'b1;
        end
      end
      default: beat = '0;
    endcase
  end

  assign beat_vld = item_vld && (item.op != OP_NONE);
  assign fire     = beat_vld && out_ok;
  assign consume  = item_vld && ((item.op == OP_NONE) || (fire && beat.last_of_run));
  assign sum_q    = sum_r;

  always_comb begin
    idx_nxt = idx_r;
    sum_nxt = sum_r;
    if (fire) begin
      idx_nxt = beat.last_of_run ? '0 : idx_r + idx_t'(1);
      if (beat.last_of_run) begin
        if (item.op == OP_START) begin
          sum_nxt = FRM_HOST_TFI;
        end else if (item.op == OP_DATA) begin
          sum_nxt = sum_r + item.payload_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      sum_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

### rtl/core/nhfe_out_reg.sv
module nhfe_out_reg
  import nhfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       beat_vld,
  input  beat_t      beat,
  output logic       out_ok,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic       out_tuser
);

  logic  valid_r, valid_nxt;
  beat_t beat_r;

  assign out_ok     = !valid_r || out_tready;
  assign valid_nxt  = out_ok ? beat_vld : valid_r;
  assign out_tvalid = valid_r;
  assign out_tdata  = beat_r.frame_byte;
  assign out_tlast  = beat_r.last_of_run;
  assign out_tuser  = beat_r.frame_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ok && beat_vld) begin
      beat_r <= beat;
    end
  end

endmodule

### rtl/core/nfc_host_frame_encoder.sv
// The first output beat of an item passes through the input register, then the
// output register.
// Throughput: one output beat per cycle while items wait and out_tready is high,
// set by the output register; a start item gives six beats, a payload item one, a finish item two.
// An unused op is dropped with no output.
// Reset (rst_n low, synchronous) empties both registers and clears the
// byte index and the running checksum to zero.
module nfc_host_frame_encoder
  import nhfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] payload_len, [15:8] payload_byte
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] frame_byte
  output logic        out_tlast,
  output logic        out_tuser   // [0] frame_done
);

  item_t      in_item, item;
  beat_t      beat;
  logic       item_vld, consume, beat_vld, out_ok;
  logic [7:0] sum_q;

  assign in_item.op           = in_tuser;
  assign in_item.payload_len  = in_tdata[7:0];
  assign in_item.payload_byte = in_tdata[15:8];

  nhfe_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .consume  (consume),
    .item_vld (item_vld),
    .item     (item)
  );

  nhfe_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld),
    .item     (item),
    .out_ok   (out_ok),
    .beat_vld (beat_vld),
    .beat     (beat),
    .consume  (consume),
    .sum_q    (sum_q)
  );

  nhfe_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_vld   (beat_vld),
    .beat       (beat),
    .out_ok     (out_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_done_is_postamble: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == FRM_POSTAMBLE))
    else $error("frame_done beat is not a final postamble");

  a_start_seeds_sum: assert property (@(posedge clk) disable iff (!rst_n)
    beat_vld && out_ok && beat.last_of_run && (item.op == OP_START)
    |=> sum_q == FRM_HOST_TFI)
    else $error("checksum not seeded after header");

  a_none_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && (item.op == OP_NONE) |-> !beat_vld && consume)
    else $error("unused op produced a beat or stalled");

  a_consume_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    consume |-> item_vld)
    else $error("consume without a held item");

endmodule

### verif/nfc_host_frame_encoder_tb.sv
module nfc_host_frame_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nhfe_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 8;
  localparam int ITEM_TARGET    = 470;

  class frame_scoreboard;
    beat_t      expected_beats[$];
    logic [7:0] data_sum;
    int         errors;

    function new();
      data_sum = 8'h00;
      errors   = 0;
    endfunction

    function void push_beat(logic [7:0] b, logic last, logic done);
      beat_t e;
      e.frame_byte  = b;
      e.last_of_run = last;
      e.frame_done  = done;
      expected_beats.push_back(e);
    endfunction

    function void note_item(item_t it);
      logic [7:0] len;
      len = it.payload_len + 8'd1;
      case (it.op)
        OP_START: begin
          push_beat(FRM_PREAMBLE, 1'b0, 1'b0);
          push_beat(FRM_START1, 1'b0, 1'b0);
          push_beat(FRM_START2, 1'b0, 1'b0);
          push_beat(len, 1'b0, 1'b0);
          push_beat(8'h00 - len, 1'b0, 1'b0);
          push_beat(FRM_HOST_TFI, 1'b1, 1'b0);
          data_sum = FRM_HOST_TFI;
        end
        OP_DATA: begin
          data_sum = data_sum + it.payload_byte;
          push_beat(it.payload_byte, 1'b1, 1'b0);
        end
        OP_FINISH: begin
          push_beat(8'h00 - data_sum, 1'b0, 1'b0);
          push_beat(FRM_POSTAMBLE, 1'b1, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_beat(beat_t got);
      beat_t e;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat byte=%02h last=%0b done=%0b", $time,
                 got.frame_byte, got.last_of_run, got.frame_done);
        return;
      end
      e = expected_beats.pop_front();
      if (got.frame_byte !== e.frame_byte) begin
        errors++;
        $display("%0t: frame_byte exp %02h got %02h", $time, e.frame_byte, got.frame_byte);
      end
      if (got.last_of_run !== e.last_of_run) begin
        errors++;
        $display("%0t: last_of_run exp %0b got %0b", $time, e.last_of_run, got.last_of_run);
      end
      if (got.frame_done !== e.frame_done) begin
        errors++;
        $display("%0t: frame_done exp %0b got %0b", $time, e.frame_done, got.frame_done);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0000;
  logic [1:0]  in_tuser = OP_NONE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  frame_scoreboard sb;
  bit              no_idle = 1'b0;
  bit              beat_taken = 1'b0;
  int              rx_wait = 0;
  int              idle_cycles = 0;
  int              items_sent = 0;

  nfc_host_frame_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    item_t it;
    beat_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        it.op           = in_tuser;
        it.payload_len  = in_tdata[7:0];
        it.payload_byte = in_tdata[15:8];
        sb.note_item(it);
      end
      if (out_tvalid && out_tready) begin
        got.frame_byte  = out_tdata;
        got.last_of_run = out_tlast;
        got.frame_done  = out_tuser;
        sb.check_beat(got);
        beat_taken = 1'b1;
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("nfc_host_frame_encoder_tb failed");
        $finish;
      end
    end
  end

  // receiver: fresh stall drawn per accepted beat
  always @(negedge clk) begin
    if (beat_taken) begin
      rx_wait    = no_idle ? 0 : $urandom_range(0, 3);
      beat_taken = 1'b0;
    end
    if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] plen,
                           input logic [7:0] pbyte);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0 && in_tvalid) in_tvalid <= 1'b0;
    repeat (gap) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pbyte, plen};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic send_frame(input int n_data);
    send_item(OP_START, 8'($urandom), 8'($urandom));
    for (int i = 0; i < n_data; i++) send_item(OP_DATA, 8'($urandom), 8'($urandom));
    send_item(OP_FINISH, 8'($urandom), 8'($urandom));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.expected_beats.size() != 0);
  endtask

  initial begin
    bit paused;
    sb     = new();
    paused = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // finish and payload without a start, then unused op
    send_item(OP_FINISH, 8'h00, 8'h00);
    send_item(OP_DATA, 8'h00, 8'hFF);
    send_item(OP_FINISH, 8'hFF, 8'h00);
    send_item(OP_NONE, 8'hFF, 8'hFF);
    send_item(OP_START, 8'h00, 8'h00);
    send_item(OP_DATA, 8'h00, 8'h00);
    send_item(OP_DATA, 8'hFF, 8'hFF);
    send_item(OP_NONE, 8'h55, 8'hAA);
    send_item(OP_DATA, 8'h5A, 8'hA5);
    send_item(OP_FINISH, 8'h00, 8'h00);
    // length wrap
    send_item(OP_START, 8'hFF, 8'h00);
    send_item(OP_DATA, 8'h00, 8'h2C);
    send_item(OP_FINISH, 8'h00, 8'h00);
    send_item(OP_START, 8'hFE, 8'hFF);
    send_item(OP_FINISH, 8'h00, 8'h00);
    // sum kept past finish
    send_item(OP_DATA, 8'h00, 8'h01);
    send_item(OP_FINISH, 8'h00, 8'h00);
    send_item(OP_START, 8'h80, 8'h00);
    send_item(OP_START, 8'h7F, 8'h00);
    send_item(OP_FINISH, 8'h00, 8'h00);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) no_idle = !no_idle;
      if (!paused && items_sent > ITEM_TARGET / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) send_frame($urandom_range(0, 10));
      else send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("nfc_host_frame_encoder_tb passed");
    end else begin
      $display("nfc_host_frame_encoder_tb failed");
    end
    $finish;
  end

endmodule
